[rtl/schc_fragmenter_crc8_top_defines.svh]
// Assertion macros for the SCHC fragmenter checker.
// SCHCF_ASSERT expects signals named clk and arst_n, SCHCF_ASSERT_ALWAYS one named clk, in the scope where it is used.
`ifndef SCHC_FRAGMENTER_CRC8_TOP_DEFINES_SVH
`define SCHC_FRAGMENTER_CRC8_TOP_DEFINES_SVH
// check on every clock edge outside reset
`define SCHCF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
// check on every clock edge, reset included
`define SCHCF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

[rtl/schcf_pkg.sv]
// Shared types and constants of the SCHC fragmenter with CRC-8.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package schcf_pkg;

	localparam logic [7:0] CRC_POLY    = 8'h31;
	localparam logic [7:0] CRC_INIT    = 8'hFF;
	localparam logic [2:0] FINAL_INDEX = 3'h7;
	localparam logic [1:0] RULE_RESET  = 2'd1;

	// commands from the controller to the datapath
	typedef struct packed {
		logic store;       // write the accepted byte, fold it into the CRC
		logic start;       // snapshot count and CRC, clear them for the next message
		logic frag_begin;  // set up the next fragment
		logic shift;       // place one packet byte into the word being built
		logic put;         // move the finished word into the output register
	} dp_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic word_end;    // the byte being placed closes the word
		logic frag_end;    // the finished word closes its fragment
		logic msg_done;    // the current fragment is the last one of the burst
		logic out_free;    // the output register can take a word this cycle
	} dp_sts_t;

	// CRC-8, MSB first, no reflection
	function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

[rtl/schcf_msg_if.sv]
// Message byte channel: valid/ready handshake carrying one byte and a last flag.
// No dependencies.
`timescale 1ns / 1ps
interface schcf_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, data_byte, last_byte, input ready);
	modport sink (input valid, data_byte, last_byte, output ready);
endinterface

[rtl/schcf_pkt_if.sv]
// Packet word channel: valid/ready handshake carrying one 64-bit word and its tags.
// No dependencies.
`timescale 1ns / 1ps
interface schcf_pkt_if;
	logic        valid;
	logic        ready;
	logic [63:0] packet_word;
	logic [3:0]  word_bytes;
	logic [2:0]  fragment_number;
	logic        end_of_fragment;
	logic        end_of_message;

	modport source (output valid, packet_word, word_bytes, fragment_number,
		end_of_fragment, end_of_message, input ready);
	modport sink (input valid, packet_word, word_bytes, fragment_number,
		end_of_fragment, end_of_message, output ready);
endinterface

[rtl/schc_fragmenter_crc8_top.sv]
// Top level of the SCHC No-ACK fragmenter with CRC-8 check.
// Depends on schcf_pkg, schcf_msg_if, schcf_pkt_if, schcf_ctrl and schcf_dpath.
`timescale 1ns / 1ps
// Message bytes are taken one per cycle on msg while the block is idle; each is
// stored and folded into a CRC-8 (poly 0x31, init 0xFF) while the message memory
// has room. The transfer that carries last_byte starts a burst of fragments on pkt,
// each sent as 64-bit words, earliest byte in bits 63:56. The burst has a start
// step, then per fragment a setup step, per packet byte a message memory read and
// then placement into the word, and per word a move into the output register that
// waits while the output is stalled. msg is not ready during the burst and is ready
// again once the last word sits in the output register. The user must see that
// rule_number is written through cfg_we/cfg_wdata only while the block is idle;
// the block itself does not enforce this.
module schc_fragmenter_crc8_top #(
	parameter int unsigned MESSAGE_DEPTH = 256,
	parameter int unsigned PACKET_BYTES  = 20,
	parameter int unsigned MAX_FRAGMENTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	schcf_msg_if.sink   msg,
	schcf_pkt_if.source pkt
);

	schcf_pkg::dp_cmd_t cmd;
	schcf_pkg::dp_sts_t sts;

	// sequence the receive and emission phases
	schcf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg.valid),
		.msg_last  (msg.last_byte),
		.msg_ready (msg.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// store, check and assemble words
	schcf_dpath #(
		.MESSAGE_DEPTH (MESSAGE_DEPTH),
		.PACKET_BYTES  (PACKET_BYTES),
		.MAX_FRAGMENTS (MAX_FRAGMENTS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.data_byte       (msg.data_byte),
		.cmd             (cmd),
		.sts             (sts),
		.pkt_ready       (pkt.ready),
		.pkt_valid       (pkt.valid),
		.packet_word     (pkt.packet_word),
		.word_bytes      (pkt.word_bytes),
		.fragment_number (pkt.fragment_number),
		.end_of_fragment (pkt.end_of_fragment),
		.end_of_message  (pkt.end_of_message)
	);

endmodule

[rtl/schcf_ctrl.sv]
// Controller state machine of the SCHC fragmenter.
// Depends on schcf_pkg for the command and status structs.
`timescale 1ns / 1ps
module schcf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               msg_valid,
	input  logic               msg_last,
	output logic               msg_ready,
	input  schcf_pkg::dp_sts_t sts,
	output schcf_pkg::dp_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_FRAG  = 3'd2;
	localparam logic [2:0] ST_RD    = 3'd3;
	localparam logic [2:0] ST_SH    = 3'd4;
	localparam logic [2:0] ST_PUT   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		msg_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				msg_ready = 1'b1;
				if (msg_valid) begin
					cmd.store = 1'b1;
					if (msg_last) begin
						state_d = ST_START;
					end
				end
			end
			ST_START: begin
				cmd.start = 1'b1;
				state_d   = ST_FRAG;
			end
			ST_FRAG: begin
				cmd.frag_begin = 1'b1;
				state_d        = ST_RD;
			end
			// memory read of the current address settles here
			ST_RD: begin
				state_d = ST_SH;
			end
			ST_SH: begin
				cmd.shift = 1'b1;
				state_d   = sts.word_end ? ST_PUT : ST_RD;
			end
			ST_PUT: begin
				if (sts.out_free) begin
					cmd.put = 1'b1;
					priority if (!sts.frag_end) begin
						state_d = ST_RD;
					end else if (sts.msg_done) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_FRAG;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/schcf_dpath.sv]
// Datapath of the SCHC fragmenter: message memory, CRC, fragment counters,
// word assembly and the output register. Depends on schcf_pkg.
`timescale 1ns / 1ps
module schcf_dpath #(
	parameter int unsigned MESSAGE_DEPTH = 256,
	parameter int unsigned PACKET_BYTES  = 20,
	parameter int unsigned MAX_FRAGMENTS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_wdata,
	input  logic [7:0]         data_byte,
	input  schcf_pkg::dp_cmd_t cmd,
	output schcf_pkg::dp_sts_t sts,
	input  logic               pkt_ready,
	output logic               pkt_valid,
	output logic [63:0]        packet_word,
	output logic [3:0]         word_bytes,
	output logic [2:0]         fragment_number,
	output logic               end_of_fragment,
	output logic               end_of_message
);

	localparam int unsigned AW = $clog2(MESSAGE_DEPTH);
	localparam int unsigned CW = $clog2(MESSAGE_DEPTH + 1);
	localparam int unsigned JW = $clog2(PACKET_BYTES);
	localparam logic [CW-1:0] DEPTH_C   = CW'(MESSAGE_DEPTH);
	localparam logic [CW-1:0] FINAL_MAX = CW'(PACKET_BYTES - 2);
	localparam logic [JW-1:0] FINAL_TK  = JW'(PACKET_BYTES - 2);
	localparam logic [JW-1:0] MID_TAKE  = JW'(PACKET_BYTES - 1);
	localparam logic [JW-1:0] LAST_J    = JW'(PACKET_BYTES - 1);
	localparam logic [2:0]    LAST_FRAG = 3'(MAX_FRAGMENTS - 1);

	logic [7:0]    mem [MESSAGE_DEPTH];
	logic [7:0]    rdata_q;
	logic [1:0]    rule_q;
	logic [CW-1:0] cnt_q;
	logic [7:0]    crc_q;
	logic [7:0]    crc_snap_q;
	logic [CW-1:0] rem_q;
	logic [AW-1:0] addr_q;
	logic [2:0]    frag_q;
	logic          final_q;
	logic [JW-1:0] pay_left_q;
	logic [JW-1:0] j_q;
	logic [2:0]    lane_q;
	logic [63:0]   word_q;
	logic [3:0]    nb_q;
	logic          eof_q;
	logic          out_valid_q;
	logic [63:0]   out_word_q;
	logic [3:0]    out_nb_q;
	logic [2:0]    out_frag_q;
	logic          out_eof_q;
	logic          out_eom_q;

	logic          wr_en;
	logic          fin_next;
	logic [JW-1:0] take;
	logic [7:0]    hdr;
	logic [7:0]    nbyte;
	logic          is_pay;

	assign wr_en = cmd.store && (cnt_q < DEPTH_C);

	// message memory: write at the fill count, read at the payload address
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_q[AW-1:0]] <= data_byte;
		end
		rdata_q <= mem[addr_q];
	end

	// fragment setup: final when few bytes remain or at the last slot
	always_comb begin
		fin_next = (rem_q <= FINAL_MAX) || (frag_q == LAST_FRAG);
		if (!fin_next) begin
			take = MID_TAKE;
		end else if (rem_q <= FINAL_MAX) begin
			take = JW'(rem_q);
		end else begin
			take = FINAL_TK;
		end
	end

	// pick the packet byte at position j_q
	always_comb begin
		hdr    = {rule_q, (final_q ? schcf_pkg::FINAL_INDEX : frag_q),
			(final_q ? crc_snap_q[7:5] : 3'b000)};
		is_pay = 1'b0;
		priority if (j_q == '0) begin
			nbyte = hdr;
		end else if (final_q && (j_q == JW'(1))) begin
			nbyte = {crc_snap_q[4:0], 3'b000};
		end else if (pay_left_q != '0) begin
			nbyte  = rdata_q;
			is_pay = 1'b1;
		end else begin
			nbyte = 8'h00;
		end
	end

	assign sts.word_end = (lane_q == 3'd7) || (j_q == LAST_J);
	assign sts.frag_end = eof_q;
	assign sts.msg_done = final_q || (rem_q == '0);
	assign sts.out_free = !out_valid_q || pkt_ready;

	// rule register, fill count and running CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q <= schcf_pkg::RULE_RESET;
			cnt_q  <= '0;
			crc_q  <= schcf_pkg::CRC_INIT;
		end else begin
			if (cfg_we) begin
				rule_q <= cfg_wdata;
			end
			if (cmd.start) begin
				cnt_q <= '0;
				crc_q <= schcf_pkg::CRC_INIT;
			end else if (wr_en) begin
				cnt_q <= cnt_q + CW'(1);
				crc_q <= schcf_pkg::crc_fold(crc_q, data_byte);
			end
		end
	end

	// fragment counters and word assembly
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			crc_snap_q <= crc_q;
			rem_q      <= cnt_q;
			addr_q     <= '0;
			frag_q     <= '0;
		end
		if (cmd.frag_begin) begin
			final_q    <= fin_next;
			pay_left_q <= take;
			rem_q      <= rem_q - CW'(take);
			j_q        <= '0;
			lane_q     <= '0;
		end
		if (cmd.shift) begin
			for (int l = 0; l < 8; l++) begin
				if (lane_q == 3'(l)) begin
					word_q[63 - 8 * l -: 8] <= nbyte;
				end else if (lane_q == 3'd0) begin
					word_q[63 - 8 * l -: 8] <= 8'h00;
				end
			end
			if (is_pay) begin
				addr_q     <= addr_q + AW'(1);
				pay_left_q <= pay_left_q - JW'(1);
			end
			j_q <= j_q + JW'(1);
			if (sts.word_end) begin
				lane_q <= 3'd0;
				nb_q   <= {1'b0, lane_q} + 4'd1;
				eof_q  <= (j_q == LAST_J);
			end else begin
				lane_q <= lane_q + 3'd1;
			end
		end
		if (cmd.put && eof_q) begin
			frag_q <= frag_q + 3'd1;
		end
	end

	// output register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.put) begin
			out_valid_q <= 1'b1;
		end else if (pkt_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register: payload
	always_ff @(posedge clk) begin
		if (cmd.put) begin
			out_word_q <= word_q;
			out_nb_q   <= nb_q;
			out_frag_q <= frag_q;
			out_eof_q  <= eof_q;
			out_eom_q  <= eof_q && final_q;
		end
	end

	assign pkt_valid       = out_valid_q;
	assign packet_word     = out_word_q;
	assign word_bytes      = out_nb_q;
	assign fragment_number = out_frag_q;
	assign end_of_fragment = out_eof_q;
	assign end_of_message  = out_eom_q;

endmodule

[rtl/schcf_checker.sv]
// Port-level checker for the SCHC fragmenter, bound to the top level.
// Depends on schc_fragmenter_crc8_top_defines.svh for the assertion macros.
`timescale 1ns / 1ps
`include "schc_fragmenter_crc8_top_defines.svh"
module schcf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        msg_valid,
	input logic        msg_ready,
	input logic        msg_last,
	input logic        pkt_valid,
	input logic        pkt_ready,
	input logic [63:0] packet_word,
	input logic [3:0]  word_bytes,
	input logic        end_of_fragment,
	input logic        end_of_message
);

	// no word is offered while reset is applied
	`SCHCF_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !pkt_valid, "word valid in reset")
	// a last-byte transfer closes the input for the burst
	`SCHCF_ASSERT(a_last_closes, (msg_valid && msg_ready && msg_last) |=> !msg_ready, "msg ready after last byte")
	// only the closing word of a fragment may be short
	`SCHCF_ASSERT(a_full_words, (pkt_valid && !end_of_fragment) |-> (word_bytes == 4'd8), "short word inside fragment")
	// end of message only on a fragment boundary
	`SCHCF_ASSERT(a_eom_on_eof, (pkt_valid && end_of_message) |-> end_of_fragment, "end of message mid fragment")
	// a stalled word holds
	`SCHCF_ASSERT(a_stall_hold, (pkt_valid && !pkt_ready) |=> (pkt_valid && $stable(packet_word)), "stalled word changed")

endmodule

bind schc_fragmenter_crc8_top schcf_checker u_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.msg_valid       (msg.valid),
	.msg_ready       (msg.ready),
	.msg_last        (msg.last_byte),
	.pkt_valid       (pkt.valid),
	.pkt_ready       (pkt.ready),
	.packet_word     (pkt.packet_word),
	.word_bytes      (pkt.word_bytes),
	.end_of_fragment (pkt.end_of_fragment),
	.end_of_message  (pkt.end_of_message)
);
